// File: rtl/core/bog_pkg.sv
// Shared constants and register codes for the broadcast offset generator.
package bog_pkg;

   localparam int MAX_DIMS_DEF     = 4;
   localparam int STRIDE_WIDTH_DEF = 16;
   localparam int INDEX_WIDTH_DEF  = 32;
   localparam int CSR_WIDTH        = 64;
   localparam int RANK_WIDTH       = 3;
   localparam int QBITS            = 4;

   typedef enum logic [2:0] {
      REG_DIMS_IN_USE = 3'd0,
      REG_OUT_STRIDES = 3'd1,
      REG_A_SHAPE     = 3'd2,
      REG_A_STRIDES   = 3'd3,
      REG_A_RANK      = 3'd4,
      REG_B_SHAPE     = 3'd5,
      REG_B_STRIDES   = 3'd6,
      REG_B_RANK      = 3'd7
   } csr_index_type;

endpackage

// File: rtl/core/broadcast_offset_generator.sv
// Top level: pipelined index-to-offset generator for two broadcast inputs.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  req_linear_index
//   rsp      out  rsp_valid/rsp_stall  rsp_out_offset, rsp_a_offset, rsp_b_offset, rsp_bad_stride
//   csr      in   csr_we               csr_index, csr_wdata
//
// One word enters per cycle unless req_stall is high; the restoring divider retires four
// quotient bits per stage.
// Reset is synchronous; it empties the pipeline and loads register defaults.
// A stalled result freezes the whole pipeline; req_stall rises only then.
module broadcast_offset_generator #(
   parameter int MAX_DIMS     = bog_pkg::MAX_DIMS_DEF,
   parameter int STRIDE_WIDTH = bog_pkg::STRIDE_WIDTH_DEF,
   parameter int INDEX_WIDTH  = bog_pkg::INDEX_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [INDEX_WIDTH-1:0]         req_linear_index,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [INDEX_WIDTH-1:0]         rsp_out_offset,
   output logic [INDEX_WIDTH-1:0]         rsp_a_offset,
   output logic [INDEX_WIDTH-1:0]         rsp_b_offset,
   output logic                           rsp_bad_stride,
   input  logic                           csr_we,
   input  logic [2:0]                     csr_index,
   input  logic [bog_pkg::CSR_WIDTH-1:0]  csr_wdata
);

   localparam int IW   = INDEX_WIDTH;
   localparam int SW   = STRIDE_WIDTH;
   localparam int QB   = bog_pkg::QBITS;
   localparam int QS   = IW / QB;
   localparam int T    = MAX_DIMS * QS;
   localparam int PW   = SW + QB;
   localparam int CW   = bog_pkg::CSR_WIDTH;
   localparam int RW   = bog_pkg::RANK_WIDTH;
   localparam int NDW  = $clog2(MAX_DIMS + 1);

   typedef struct packed {
      logic [IW-1:0] idx;
      logic [IW-1:0] rest;
      logic [SW-1:0] rem;
      logic [QB-1:0] q;
      logic [IW-1:0] acc_a;
      logic [IW-1:0] acc_b;
      logic          bad;
   } stage_type;

   logic [RW-1:0] dims_ff, a_rank_ff, b_rank_ff;
   logic [CW-1:0] out_strides_ff, a_shape_ff, a_strides_ff, b_shape_ff, b_strides_ff;

   stage_type stg_ff [T+1];
   stage_type stg_in [T+1];
   logic      vld_ff [T+1];
   stage_type out_ff, out_in;
   logic      out_vld_ff;
   logic      adv;

   logic [NDW-1:0] n_dims;
   logic [SW-1:0]  pad_a [MAX_DIMS];
   logic [SW-1:0]  pad_b [MAX_DIMS];

   function automatic logic [SW-1:0] field_at(input logic [CW-1:0] w, input int pos);
      logic [SW-1:0] f;
      f = '0;
      if (pos * SW < CW) begin
         f = SW'(w >> (pos * SW));
      end
      return f;
   endfunction

   function automatic logic [SW-1:0] pad_of(input logic [CW-1:0] shp, input logic [CW-1:0] str,
                                           input logic [RW-1:0] rank, input int n, input int i);
      int r;
      int k;
      logic [SW-1:0] p;
      p = '0;
      r = (int'(rank) > n) ? n : int'(rank);
      k = n - 1 - i;
      if (i < n && k < r && field_at(shp, k) != SW'(1)) begin
         p = field_at(str, k);
      end
      return p;
   endfunction

   function automatic logic [IW-1:0] term(input logic [QB-1:0] q, input logic [SW-1:0] p,
                                          input int jp);
      logic [PW-1:0]    prod;
      logic [IW+PW-1:0] w;
      prod = PW'(q) * PW'(p);
      w    = (IW+PW)'(prod) << (IW - QB * (jp + 1));
      return w[IW-1:0];
   endfunction

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff        <= RW'(1);
         out_strides_ff <= CW'(1);
         a_shape_ff     <= '0;
         a_strides_ff   <= '0;
         a_rank_ff      <= '0;
         b_shape_ff     <= '0;
         b_strides_ff   <= '0;
         b_rank_ff      <= '0;
      end else if (csr_we) begin
         unique case (bog_pkg::csr_index_type'(csr_index))
            bog_pkg::REG_DIMS_IN_USE: dims_ff        <= csr_wdata[RW-1:0];
            bog_pkg::REG_OUT_STRIDES: out_strides_ff <= csr_wdata;
            bog_pkg::REG_A_SHAPE:     a_shape_ff     <= csr_wdata;
            bog_pkg::REG_A_STRIDES:   a_strides_ff   <= csr_wdata;
            bog_pkg::REG_A_RANK:      a_rank_ff      <= csr_wdata[RW-1:0];
            bog_pkg::REG_B_SHAPE:     b_shape_ff     <= csr_wdata;
            bog_pkg::REG_B_STRIDES:   b_strides_ff   <= csr_wdata;
            bog_pkg::REG_B_RANK:      b_rank_ff      <= csr_wdata[RW-1:0];
            default: ;
         endcase
      end
   end

   // Right-align input strides to the dimensions in use; a dimension of size one gets stride zero.
   always_comb begin
      n_dims = (int'(dims_ff) > MAX_DIMS) ? NDW'(MAX_DIMS) : NDW'(dims_ff);
      for (int i = 0; i < MAX_DIMS; i++) begin
         pad_a[i] = pad_of(a_shape_ff, a_strides_ff, a_rank_ff, int'(n_dims), i);
         pad_b[i] = pad_of(b_shape_ff, b_strides_ff, b_rank_ff, int'(n_dims), i);
      end
   end

   assign adv       = !(out_vld_ff && rsp_stall);
   assign req_stall = !adv;

   always_comb begin
      stg_in[0]       = '0;
      stg_in[0].idx   = req_linear_index;
      stg_in[0].rest  = req_linear_index;
   end

   // Each stage retires QB quotient bits; every stage but the first folds in the previous stage's bits.
   for (genvar k = 0; k < T; k++) begin : g_div
      localparam int D  = k / QS;
      localparam int J  = k % QS;
      localparam int DP = (k > 0) ? (k - 1) / QS : 0;
      localparam int JP = (k > 0) ? (k - 1) % QS : 0;

      logic [SW-1:0] stv;
      logic [SW-1:0] rm;
      logic [SW:0]   r;
      logic [QB-1:0] qv;
      logic          use_dim;

      always_comb begin
         stg_in[k+1] = stg_ff[k];
         stv     = field_at(out_strides_ff, MAX_DIMS - 1 - D);
         use_dim = (D < int'(n_dims));
         rm      = (J == 0) ? '0 : stg_ff[k].rem;
         qv      = '0;
         for (int b = 0; b < QB; b++) begin
            r = {rm, stg_ff[k].rest[IW-1-(J*QB+b)]};
            if (r >= {1'b0, stv}) begin
               r = r - {1'b0, stv};
               qv[QB-1-b] = 1'b1;
            end
            rm = r[SW-1:0];
         end
         if (use_dim && stv != '0) begin
            stg_in[k+1].rem = rm;
            stg_in[k+1].q   = qv;
            if (J == QS - 1) begin
               stg_in[k+1].rest = IW'(rm);
            end
         end else begin
            stg_in[k+1].q = '0;
         end
         if (J == 0 && use_dim && stv == '0) begin
            stg_in[k+1].bad = 1'b1;
         end
         if (k > 0) begin
            stg_in[k+1].acc_a = stg_ff[k].acc_a + term(stg_ff[k].q, pad_a[DP], JP);
            stg_in[k+1].acc_b = stg_ff[k].acc_b + term(stg_ff[k].q, pad_b[DP], JP);
         end
      end
   end

   always_comb begin
      out_in       = stg_ff[T];
      out_in.acc_a = stg_ff[T].acc_a + term(stg_ff[T].q, pad_a[MAX_DIMS-1], QS - 1);
      out_in.acc_b = stg_ff[T].acc_b + term(stg_ff[T].q, pad_b[MAX_DIMS-1], QS - 1);
   end

   for (genvar k = 0; k <= T; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= (k == 0) ? req_valid : vld_ff[(k == 0) ? 0 : k-1];
         end
         if (adv) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vld_ff[T];
      end
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_out_offset = out_ff.idx;
   assign rsp_a_offset   = out_ff.acc_a;
   assign rsp_b_offset   = out_ff.acc_b;
   assign rsp_bad_stride = out_ff.bad;

endmodule

// File: rtl/core/bog_checker.sv
// Port-level checks for the broadcast offset generator, bound to the top level.
module bog_checker #(
   parameter int INDEX_WIDTH = bog_pkg::INDEX_WIDTH_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [INDEX_WIDTH-1:0] rsp_out_offset,
   input logic [INDEX_WIDTH-1:0] rsp_a_offset,
   input logic [INDEX_WIDTH-1:0] rsp_b_offset,
   input logic                   rsp_bad_stride
);

   // Reset drains every word.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // Only a blocked output may hold back the input side.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while output is free");

   // A blocked result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_offset)
         && $stable(rsp_a_offset) && $stable(rsp_b_offset) && $stable(rsp_bad_stride)))
      else $error("stalled result word changed");

   // An empty output never holds back the input side.
   a_no_stall_idle: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid) |-> !req_stall)
      else $error("input stalled with empty output");

endmodule

bind broadcast_offset_generator bog_checker #(.INDEX_WIDTH(INDEX_WIDTH)) u_bog_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_offset (rsp_out_offset),
   .rsp_a_offset   (rsp_a_offset),
   .rsp_b_offset   (rsp_b_offset),
   .rsp_bad_stride (rsp_bad_stride)
);
